>>> hw/rtl/slr_pkg.sv
// Shared types, token and rule codes, and the SLR(1) action/goto tables
// for the expression evaluator. No dependencies.
package slr_pkg;

    localparam logic [3:0] KIND_ID     = 4'd1;
    localparam logic [3:0] KIND_NUM    = 4'd2;
    localparam logic [3:0] KIND_PLUS   = 4'd3;
    localparam logic [3:0] KIND_MINUS  = 4'd4;
    localparam logic [3:0] KIND_TIMES  = 4'd5;
    localparam logic [3:0] KIND_DIVIDE = 4'd6;
    localparam logic [3:0] KIND_OPEN   = 4'd7;
    localparam logic [3:0] KIND_CLOSE  = 4'd8;
    localparam logic [3:0] KIND_END    = 4'd9;

    localparam logic [3:0] RULE_ADD   = 4'd1;
    localparam logic [3:0] RULE_SUB   = 4'd2;
    localparam logic [3:0] RULE_E_T   = 4'd3;
    localparam logic [3:0] RULE_MUL   = 4'd4;
    localparam logic [3:0] RULE_DIV   = 4'd5;
    localparam logic [3:0] RULE_T_F   = 4'd6;
    localparam logic [3:0] RULE_F_ID  = 4'd7;
    localparam logic [3:0] RULE_PAREN = 4'd8;
    localparam logic [3:0] RULE_F_NUM = 4'd9;

    localparam logic [31:0] ID_VALUE = 32'd9999999;

    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [30:0] token_value;
    } t_token;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] result_value;
    } t_result;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYNTAX   = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_DIVZERO  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ACT_MISS,
        ACT_SHIFT,
        ACT_REDUCE,
        ACT_ACCEPT
    } t_act;

    typedef struct packed {
        t_act       typ;
        logic [4:0] arg;
    } t_action;

    typedef enum logic [1:0] {
        NT_E,
        NT_T,
        NT_F
    } t_nt;

    typedef struct packed {
        logic       ok;
        logic [4:0] st;
    } t_goto;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_ACT,
        BS_RED,
        BS_DIV,
        BS_REPORT
    } t_bstate;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

    function automatic t_action slr_action(logic [4:0] st, logic [3:0] kind);
        t_action a;
        a.typ = ACT_MISS;
        a.arg = '0;
        case (st)
            5'd0, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10: begin
                case (kind)
                    KIND_ID: begin
                        a.typ = ACT_SHIFT;
                        a.arg = 5'd4;
                    end
                    KIND_NUM: begin
                        a.typ = ACT_SHIFT;
                        a.arg = 5'd5;
                    end
                    KIND_OPEN: begin
                        a.typ = ACT_SHIFT;
                        a.arg = 5'd6;
                    end
                    default: ;
                endcase
            end
            5'd1, 5'd11: begin
                case (kind)
                    KIND_PLUS: begin
                        a.typ = ACT_SHIFT;
                        a.arg = 5'd7;
                    end
                    KIND_MINUS: begin
                        a.typ = ACT_SHIFT;
                        a.arg = 5'd8;
                    end
                    KIND_END: begin
                        if (st == 5'd1) begin
                            a.typ = ACT_ACCEPT;
                        end
                    end
                    KIND_CLOSE: begin
                        if (st == 5'd11) begin
                            a.typ = ACT_SHIFT;
                            a.arg = 5'd16;
                        end
                    end
                    default: ;
                endcase
            end
            5'd2, 5'd12, 5'd13: begin
                if (kind inside {KIND_PLUS, KIND_MINUS, KIND_CLOSE, KIND_END}) begin
                    a.typ = ACT_REDUCE;
                    a.arg = (st == 5'd2)  ? {1'b0, RULE_E_T} :
                            (st == 5'd12) ? {1'b0, RULE_ADD} : {1'b0, RULE_SUB};
                end else if (kind == KIND_TIMES) begin
                    a.typ = ACT_SHIFT;
                    a.arg = 5'd9;
                end else if (kind == KIND_DIVIDE) begin
                    a.typ = ACT_SHIFT;
                    a.arg = 5'd10;
                end
            end
            5'd3, 5'd4, 5'd5, 5'd14, 5'd15, 5'd16: begin
                if (kind inside {KIND_PLUS, KIND_MINUS, KIND_TIMES, KIND_DIVIDE,
                                 KIND_CLOSE, KIND_END}) begin
                    a.typ = ACT_REDUCE;
                    case (st)
                        5'd3:    a.arg = {1'b0, RULE_T_F};
                        5'd4:    a.arg = {1'b0, RULE_F_ID};
                        5'd5:    a.arg = {1'b0, RULE_F_NUM};
                        5'd14:   a.arg = {1'b0, RULE_MUL};
                        5'd15:   a.arg = {1'b0, RULE_DIV};
                        default: a.arg = {1'b0, RULE_PAREN};
                    endcase
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic t_goto slr_goto(logic [4:0] st, t_nt nt);
        t_goto g;
        g.ok = 1'b1;
        g.st = 5'd3;
        case (st)
            5'd0, 5'd6: begin
                case (nt)
                    NT_E:    g.st = (st == 5'd0) ? 5'd1 : 5'd11;
                    NT_T:    g.st = 5'd2;
                    default: g.st = 5'd3;
                endcase
            end
            5'd7, 5'd8: begin
                case (nt)
                    NT_E:    g.ok = 1'b0;
                    NT_T:    g.st = (st == 5'd7) ? 5'd12 : 5'd13;
                    default: g.st = 5'd3;
                endcase
            end
            5'd9, 5'd10: begin
                g.ok = (nt == NT_F);
                g.st = (st == 5'd9) ? 5'd14 : 5'd15;
            end
            default: g.ok = 1'b0;
        endcase
        return g;
    endfunction

    function automatic logic [1:0] slr_rule_len(logic [3:0] rule);
        logic [1:0] len;
        if (rule inside {RULE_ADD, RULE_SUB, RULE_MUL, RULE_DIV, RULE_PAREN}) begin
            len = 2'd3;
        end else begin
            len = 2'd1;
        end
        return len;
    endfunction

    function automatic t_nt slr_rule_lhs(logic [3:0] rule);
        t_nt nt;
        if (rule inside {RULE_ADD, RULE_SUB, RULE_E_T}) begin
            nt = NT_E;
        end else if (rule inside {RULE_MUL, RULE_DIV, RULE_T_F}) begin
            nt = NT_T;
        end else begin
            nt = NT_F;
        end
        return nt;
    endfunction

endpackage

>>> hw/rtl/slr_expression_evaluator.sv
// SLR(1) expression evaluator top level: token queue in front of the parser
// engine. Depends on slr_pkg, slr_front, slr_back (and slr_div below it).
//
// Tokens enter through a 4-beat queue, so the lexer can keep sending while
// the parser works. The parser handles one token at a time: a shift goes
// through fetch and act, each reduction adds a stack read and a goto and
// arithmetic step, a division reduction also waits for the bit-serial
// divider, and a report (accept or error) loads the result register. After
// an error, tokens up to the end token are dropped at one per cycle while
// the queue holds them. The stacks live in RAM of STACK_DEPTH entries; no
// clearing pass is needed after reset.
module slr_expression_evaluator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  slr_pkg::t_token  i_token,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output slr_pkg::t_result o_result
);
    import slr_pkg::*;

    logic op_valid;
    logic op_pop;
    t_op  op;

    slr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_token    (i_token),
        .o_op_valid (op_valid),
        .i_op_pop   (op_pop),
        .o_op       (op)
    );

    slr_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (op_valid),
        .i_op        (op),
        .o_op_pop    (op_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

endmodule

>>> hw/rtl/slr_front.sv
// Token intake: classifies each token into a kind and stack value and
// queues it for the parser. Depends on slr_pkg.
module slr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  slr_pkg::t_token i_token,
    output logic           o_op_valid,
    input  logic           i_op_pop,
    output slr_pkg::t_op   o_op
);
    import slr_pkg::*;

    t_op               r_q [QUEUE_DEPTH];
    logic [QIDX_W-1:0] r_wp;
    logic [QIDX_W-1:0] r_rp;
    logic [QIDX_W:0]   r_cnt;
    t_op               op_in;
    logic              push;
    logic              pop;

    always_comb begin
        op_in.kind = i_token.token_kind;
        case (i_token.token_kind)
            KIND_ID:  op_in.value = ID_VALUE;
            KIND_NUM: op_in.value = {1'b0, i_token.token_value};
            default:  op_in.value = '0;
        endcase
    end

    assign o_in_ready = (r_cnt != (QIDX_W + 1)'(QUEUE_DEPTH));
    assign o_op_valid = (r_cnt != '0);
    assign o_op       = r_q[r_rp];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_op_pop && o_op_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= op_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/slr_div.sv
// Sequential signed divider, one quotient bit per cycle, truncating.
// Depends on slr_pkg.
module slr_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slr_pkg::t_div_req  i_req,
    output slr_pkg::t_div_rsp  o_rsp
);
    import slr_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_q;
    logic [31:0] r_d;
    logic        r_neg;
    logic [32:0] trial;
    logic        ge;

    assign trial = {r_rem, r_q[31]};
    assign ge    = (trial >= {1'b0, r_d});

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (32'd0 - r_q) : r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
            r_d   <= i_req.divisor[31] ? (32'd0 - i_req.divisor) : i_req.divisor;
            r_rem <= '0;
            r_neg <= i_req.dividend[31] ^ i_req.divisor[31];
        end else if (r_busy) begin
            r_rem <= ge ? 32'(trial - {1'b0, r_d}) : trial[31:0];
            r_q   <= {r_q[30:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/slr_back.sv
// Parser engine: state and value stacks, action/goto sequencing, reductions
// and the result register. Depends on slr_pkg and slr_div.
module slr_back #(
    parameter int STACK_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_op_valid,
    input  slr_pkg::t_op     i_op,
    output logic             o_op_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output slr_pkg::t_result o_result
);
    import slr_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH);

    t_bstate         r_state;
    t_bstate         n_state;
    logic [SP_W-1:0] r_sp;
    logic [4:0]      r_top_st;
    logic [31:0]     r_top_val;
    logic [3:0]      r_kind;
    logic [31:0]     r_pval;
    logic            r_discard;
    logic [3:0]      r_rule;
    t_status         r_status;
    logic [31:0]     r_res;
    logic [4:0]      mem_st  [STACK_DEPTH];
    logic [31:0]     mem_val [STACK_DEPTH];
    logic [4:0]      r_st_rd;
    logic [31:0]     r_val_rd;
    logic            r_rd_zero;
    logic [4:0]      r_pend_st;
    logic [SP_W-1:0] r_pend_sp;
    logic            r_out_valid;
    t_result         r_out;

    t_div_req        div_req;
    t_div_rsp        div_rsp;
    t_action         act;
    logic [3:0]      act_rule;
    logic [1:0]      act_len;
    logic            a_push;
    logic            a_accept;
    logic            a_reduce;
    logic            a_err;
    t_status         a_code;
    logic [SP_W-1:0] st_addr;
    logic [SP_W-1:0] val_addr;
    logic [SP_W-1:0] base_sp;
    t_goto           gt;
    logic            red_err;
    logic [31:0]     red_val;
    logic            out_free;
    logic            push_we;

    slr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        act      = slr_action(r_top_st, r_kind);
        act_rule = act.arg[3:0];
        act_len  = slr_rule_len(act_rule);
        a_push   = 1'b0;
        a_accept = 1'b0;
        a_reduce = 1'b0;
        a_err    = 1'b0;
        a_code   = ST_SYNTAX;
        case (act.typ)
            ACT_SHIFT: begin
                if (r_sp == SP_W'(STACK_DEPTH - 1)) begin
                    a_err  = 1'b1;
                    a_code = ST_OVERFLOW;
                end else begin
                    a_push = 1'b1;
                end
            end
            ACT_ACCEPT: a_accept = 1'b1;
            ACT_REDUCE: begin
                if (r_sp < SP_W'(act_len)) begin
                    a_err = 1'b1;
                end else if (act_rule == RULE_DIV && r_top_val == '0) begin
                    a_err  = 1'b1;
                    a_code = ST_DIVZERO;
                end else begin
                    a_reduce = 1'b1;
                end
            end
            default: a_err = 1'b1;
        endcase
        st_addr  = r_sp - SP_W'(act_len);
        val_addr = r_sp - ((act_rule == RULE_PAREN) ? SP_W'(1) : SP_W'(2));
    end

    always_comb begin
        gt      = slr_goto(r_rd_zero ? 5'd0 : r_st_rd, slr_rule_lhs(r_rule));
        red_err = !gt.ok;
        base_sp = r_sp - SP_W'(slr_rule_len(r_rule)) + SP_W'(1);
        case (r_rule)
            RULE_ADD:   red_val = r_val_rd + r_top_val;
            RULE_SUB:   red_val = r_val_rd - r_top_val;
            RULE_MUL:   red_val = 32'(r_val_rd * r_top_val);
            RULE_PAREN: red_val = r_val_rd;
            default:    red_val = r_top_val;
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_op_valid && !r_discard) begin
                    n_state = BS_ACT;
                end
            end
            BS_ACT: begin
                if (a_push) begin
                    n_state = BS_IDLE;
                end else if (a_reduce) begin
                    n_state = BS_RED;
                end else begin
                    n_state = BS_REPORT;
                end
            end
            BS_RED: begin
                if (red_err) begin
                    n_state = BS_REPORT;
                end else if (r_rule == RULE_DIV) begin
                    n_state = BS_DIV;
                end else begin
                    n_state = BS_ACT;
                end
            end
            BS_DIV: begin
                if (div_rsp.done) begin
                    n_state = BS_ACT;
                end
            end
            BS_REPORT: begin
                if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_op_pop         = (r_state == BS_IDLE) && i_op_valid;
        push_we          = (r_state == BS_ACT) && a_push;
        div_req.start    = (r_state == BS_RED) && !red_err && (r_rule == RULE_DIV);
        div_req.dividend = r_val_rd;
        div_req.divisor  = r_top_val;
    end

    always_ff @(posedge i_clk) begin
        if (push_we) begin
            mem_st[r_sp]  <= r_top_st;
            mem_val[r_sp] <= r_top_val;
        end
        r_st_rd   <= mem_st[st_addr];
        r_val_rd  <= mem_val[val_addr];
        r_rd_zero <= (st_addr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_sp        <= '0;
            r_top_st    <= '0;
            r_discard   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == BS_REPORT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                BS_IDLE: begin
                    if (i_op_valid) begin
                        if (r_discard) begin
                            if (i_op.kind == KIND_END) begin
                                r_discard <= 1'b0;
                            end
                        end else begin
                            r_kind <= i_op.kind;
                            r_pval <= i_op.value;
                        end
                    end
                end
                BS_ACT: begin
                    r_rule <= act_rule;
                    r_res  <= r_top_val;
                    if (a_push) begin
                        r_sp      <= r_sp + SP_W'(1);
                        r_top_st  <= act.arg;
                        r_top_val <= r_pval;
                    end else if (a_err) begin
                        r_status <= a_code;
                    end else if (a_accept) begin
                        r_status <= ST_OK;
                    end
                end
                BS_RED: begin
                    if (red_err) begin
                        r_status <= ST_SYNTAX;
                    end else if (r_rule == RULE_DIV) begin
                        r_pend_st <= gt.st;
                        r_pend_sp <= base_sp;
                    end else begin
                        r_sp      <= base_sp;
                        r_top_st  <= gt.st;
                        r_top_val <= red_val;
                    end
                end
                BS_DIV: begin
                    if (div_rsp.done) begin
                        r_sp      <= r_pend_sp;
                        r_top_st  <= r_pend_st;
                        r_top_val <= div_rsp.quotient;
                    end
                end
                BS_REPORT: begin
                    if (out_free) begin
                        r_out.status        <= r_status;
                        r_out.result_value  <= (r_status == ST_OK) ? r_res : '0;
                        r_sp                <= '0;
                        r_top_st            <= '0;
                        r_discard           <= (r_status != ST_OK) && (r_kind != KIND_END);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule
